FILE: hw/rtl/cfc_pkg.sv
// shared types, constants and a decode function for the canopen frame classifier
package cfc_pkg;

	// field widths
	localparam int unsigned CAN_ID_W   = 11;
	localparam int unsigned LEN_W      = 4;
	localparam int unsigned PAYLOAD_W  = 64;
	localparam int unsigned NODE_W     = 7;
	localparam int unsigned CLASS_W    = 4;
	localparam int unsigned PDO_W      = 3;
	localparam int unsigned CMD_W      = 3;
	localparam int unsigned BYTE_W     = 8;
	localparam int unsigned WORD_W     = 32;
	localparam int unsigned REASON_W   = 5;
	localparam int unsigned TYPE_W     = 3;

	// stream and configuration port widths
	localparam int unsigned S_TDATA_W  = 80;
	localparam int unsigned M_TDATA_W  = 72;
	localparam int unsigned M_TUSER_W  = 5;
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 11;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_FILTER_ENABLE      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ID_MIN             = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ID_MAX             = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_NODE_FILTER_ENABLE = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_NODE_FILTER_ID     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_TYPE_FILTER        = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_SCAN_ENABLE        = 3'd6;

	// type filter codes
	localparam logic [TYPE_W-1:0] TF_NONE = 3'd0;
	localparam logic [TYPE_W-1:0] TF_PDO  = 3'd1;
	localparam logic [TYPE_W-1:0] TF_SDO  = 3'd2;
	localparam logic [TYPE_W-1:0] TF_EMCY = 3'd3;
	localparam logic [TYPE_W-1:0] TF_NMT  = 3'd4;
	localparam logic [TYPE_W-1:0] TF_HB   = 3'd5;

	// frame classes
	localparam logic [CLASS_W-1:0] CLS_NMT      = 4'd0;
	localparam logic [CLASS_W-1:0] CLS_EMCY     = 4'd1;
	localparam logic [CLASS_W-1:0] CLS_SYNC     = 4'd2;
	localparam logic [CLASS_W-1:0] CLS_TIME     = 4'd3;
	localparam logic [CLASS_W-1:0] CLS_TPDO     = 4'd4;
	localparam logic [CLASS_W-1:0] CLS_RPDO     = 4'd5;
	localparam logic [CLASS_W-1:0] CLS_SDO_RESP = 4'd6;
	localparam logic [CLASS_W-1:0] CLS_SDO_REQ  = 4'd7;
	localparam logic [CLASS_W-1:0] CLS_BOOTUP   = 4'd8;
	localparam logic [CLASS_W-1:0] CLS_HEARTBT  = 4'd9;
	localparam logic [CLASS_W-1:0] CLS_UNKNOWN  = 4'd10;
	localparam logic [CLASS_W-1:0] CLS_HB_EMPTY = 4'd11;

	// nmt commands
	localparam logic [CMD_W-1:0] NMT_START      = 3'd0;
	localparam logic [CMD_W-1:0] NMT_STOP       = 3'd1;
	localparam logic [CMD_W-1:0] NMT_PREOP      = 3'd2;
	localparam logic [CMD_W-1:0] NMT_RESET_NODE = 3'd3;
	localparam logic [CMD_W-1:0] NMT_RESET_COMM = 3'd4;
	localparam logic [CMD_W-1:0] NMT_UNKNOWN    = 3'd5;

	// heartbeat states
	localparam logic [CMD_W-1:0] HB_BOOTUP  = 3'd0;
	localparam logic [CMD_W-1:0] HB_STOPPED = 3'd1;
	localparam logic [CMD_W-1:0] HB_OPER    = 3'd2;
	localparam logic [CMD_W-1:0] HB_PREOP   = 3'd3;
	localparam logic [CMD_W-1:0] HB_UNKNOWN = 3'd4;

	// sdo command specifiers
	localparam logic [CMD_W-1:0] SDO_CS_UPLOAD = 3'd3;
	localparam logic [CMD_W-1:0] SDO_CS_ABORT  = 3'd4;

	// cob-id function bases
	localparam logic [CAN_ID_W-1:0] BASE_MASK = 11'h780;
	localparam logic [CAN_ID_W-1:0] BASE_EMCY = 11'h080;
	localparam logic [CAN_ID_W-1:0] ID_SYNC   = 11'h080;
	localparam logic [CAN_ID_W-1:0] ID_TIME   = 11'h100;
	localparam logic [CAN_ID_W-1:0] BASE_PDO_LO = 11'h180;
	localparam logic [CAN_ID_W-1:0] BASE_PDO_HI = 11'h500;
	localparam logic [CAN_ID_W-1:0] BASE_TPDO_HI = 11'h480;
	localparam logic [CAN_ID_W-1:0] BASE_RPDO_LO = 11'h200;
	localparam logic [CAN_ID_W-1:0] BASE_SDO_TX = 11'h580;
	localparam logic [CAN_ID_W-1:0] BASE_SDO_RX = 11'h600;
	localparam logic [CAN_ID_W-1:0] BASE_HB     = 11'h700;

	localparam int unsigned ABORT_N = 23;

	// one result item
	typedef struct packed {
		logic [REASON_W-1:0] abort_reason;
		logic                value_valid;
		logic [WORD_W-1:0]   word_value;
		logic [CMD_W-1:0]    sdo_command;
		logic [CMD_W-1:0]    heartbeat_state;
		logic [BYTE_W-1:0]   nmt_target;
		logic [CMD_W-1:0]    nmt_command;
		logic                node_found;
		logic [PDO_W-1:0]    pdo_index;
		logic [NODE_W-1:0]   node_number;
		logic [CLASS_W-1:0]  frame_class;
		logic                accepted;
	} cfc_result_t;

	// sdo abort code to reason number, zero when not listed
	function automatic logic [REASON_W-1:0] abort_lookup(input logic [WORD_W-1:0] code);
		logic [REASON_W-1:0] r;
		r = '0;
		case (code)
			32'h05030000: r = 5'd1;
			32'h05040000: r = 5'd2;
			32'h05040001: r = 5'd3;
			32'h05040002: r = 5'd4;
			32'h05040003: r = 5'd5;
			32'h05040004: r = 5'd6;
			32'h05040005: r = 5'd7;
			32'h06010000: r = 5'd8;
			32'h06010001: r = 5'd9;
			32'h06010002: r = 5'd10;
			32'h06020000: r = 5'd11;
			32'h06040041: r = 5'd12;
			32'h06040042: r = 5'd13;
			32'h06040043: r = 5'd14;
			32'h06070010: r = 5'd15;
			32'h06090011: r = 5'd16;
			32'h06090030: r = 5'd17;
			32'h06090031: r = 5'd18;
			32'h06090032: r = 5'd19;
			32'h08000000: r = 5'd20;
			32'h08000020: r = 5'd21;
			32'h08000021: r = 5'd22;
			32'h08000022: r = 5'd23;
			default:      r = '0;
		endcase
		return r;
	endfunction

endpackage

FILE: hw/rtl/canopen_frame_filter_classifier.sv
// canopen frame filter and classifier: input register, decode logic, result register
// a frame accepted on the slave side passes the input register, then the result register, which drives the master side
// throughput: one frame per cycle while the master side accepts; an empty input register fills while a result waits
// the only loop is the ready chain from the result register back to the input register
// reset (arst_n low, asynchronous) empties both stages and sets the configuration
// to filter off, id range 0..2047, node and type filter off, scan off
module canopen_frame_filter_classifier
	import cfc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	// slave side
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [S_TDATA_W-1:0]  s_axis_tdata,  // can_id, data_len, payload, zero pad
	// master side
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [M_TDATA_W-1:0]  m_axis_tdata,  // node_number, pdo_index, node_found,
	                                             // nmt_command, nmt_target, heartbeat_state,
	                                             // sdo_command, word_value, value_valid,
	                                             // abort_reason, zero pad
	output logic [M_TUSER_W-1:0]  m_axis_tuser,  // accepted, frame_class
	// configuration write channel
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	// configuration registers
	logic                filter_enable_q;
	logic [CAN_ID_W-1:0] id_min_q;
	logic [CAN_ID_W-1:0] id_max_q;
	logic                node_filter_enable_q;
	logic [NODE_W-1:0]   node_filter_id_q;
	logic [TYPE_W-1:0]   type_filter_q;
	logic                scan_enable_q;

	// pipeline registers
	logic                 valid_s1;
	logic [CAN_ID_W-1:0]  can_id_s1;
	logic [LEN_W-1:0]     data_len_s1;
	logic [PAYLOAD_W-1:0] payload_s1;
	logic                 valid_s2;
	cfc_result_t          result_s2;

	logic        adv_s2;
	logic        adv_s1;
	cfc_result_t res;

	// decode helpers
	logic [NODE_W-1:0]   node;
	logic [CAN_ID_W-1:0] base;
	logic [BYTE_W-1:0]   b0;
	logic [BYTE_W-1:0]   b1;
	logic [WORD_W-1:0]   hi_word;
	logic [WORD_W-1:0]   expd_mask;
	logic                pass;

	// handshake: result stage moves when empty or taken, input stage follows
	assign adv_s2        = !valid_s2 || m_axis_tready;
	assign adv_s1        = valid_s1 && adv_s2;
	assign s_axis_tready = !valid_s1 || adv_s2;
	assign cfg_ready     = 1'b1;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filter_enable_q      <= 1'b0;
			id_min_q             <= '0;
			id_max_q             <= '1;
			node_filter_enable_q <= 1'b0;
			node_filter_id_q     <= '0;
			type_filter_q        <= TF_NONE;
			scan_enable_q        <= 1'b0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_FILTER_ENABLE:      filter_enable_q      <= cfg_data[0];
				REG_ID_MIN:             id_min_q             <= cfg_data[CAN_ID_W-1:0];
				REG_ID_MAX:             id_max_q             <= cfg_data[CAN_ID_W-1:0];
				REG_NODE_FILTER_ENABLE: node_filter_enable_q <= cfg_data[0];
				REG_NODE_FILTER_ID:     node_filter_id_q     <= cfg_data[NODE_W-1:0];
				REG_TYPE_FILTER:        type_filter_q        <= cfg_data[TYPE_W-1:0];
				REG_SCAN_ENABLE:        scan_enable_q        <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	// input register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	// input register payload
	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			can_id_s1   <= s_axis_tdata[10:0];
			data_len_s1 <= s_axis_tdata[14:11];
			payload_s1  <= s_axis_tdata[78:15];
		end
	end

	// field extraction
	assign node    = can_id_s1[NODE_W-1:0];
	assign base    = can_id_s1 & BASE_MASK;
	assign b0      = payload_s1[7:0];
	assign b1      = payload_s1[15:8];
	assign hi_word = payload_s1[63:32];

	// expedited upload keeps 4-n bytes from byte 4
	always_comb begin
		case (b0[3:2])
			2'd0:    expd_mask = 32'hFFFF_FFFF;
			2'd1:    expd_mask = 32'h00FF_FFFF;
			2'd2:    expd_mask = 32'h0000_FFFF;
			default: expd_mask = 32'h0000_00FF;
		endcase
	end

	// acceptance filter
	always_comb begin
		pass = 1'b1;
		if (filter_enable_q) begin
			if (can_id_s1 < id_min_q || can_id_s1 > id_max_q)
				pass = 1'b0;
			if (node_filter_enable_q && node != node_filter_id_q)
				pass = 1'b0;
			case (type_filter_q)
				TF_PDO:  if (!(base >= BASE_PDO_LO && base <= BASE_PDO_HI)) pass = 1'b0;
				TF_SDO:  if (!(base == BASE_SDO_TX || base == BASE_SDO_RX)) pass = 1'b0;
				TF_EMCY: if (base != BASE_EMCY) pass = 1'b0;
				TF_NMT:  if (can_id_s1 != '0) pass = 1'b0;
				TF_HB:   if (base != BASE_HB) pass = 1'b0;
				default: begin
				end
			endcase
		end
	end

	// classification and payload decode
	always_comb begin
		res             = '0;
		res.accepted    = 1'b1;
		res.node_number = node;
		if (can_id_s1 == '0) begin
			res.frame_class = CLS_NMT;
			if (data_len_s1 >= 4'd2) begin
				res.nmt_target = b1;
				unique case (b0)
					8'h01:   res.nmt_command = NMT_START;
					8'h02:   res.nmt_command = NMT_STOP;
					8'h80:   res.nmt_command = NMT_PREOP;
					8'h81:   res.nmt_command = NMT_RESET_NODE;
					8'h82:   res.nmt_command = NMT_RESET_COMM;
					default: res.nmt_command = NMT_UNKNOWN;
				endcase
			end else begin
				res.nmt_command = NMT_UNKNOWN;
			end
		end else if (base == BASE_EMCY && node != '0) begin
			res.frame_class = CLS_EMCY;
			if (data_len_s1 >= 4'd2) begin
				res.word_value  = {16'h0000, b1, b0};
				res.value_valid = 1'b1;
			end
		end else if (can_id_s1 == ID_SYNC) begin
			res.frame_class = CLS_SYNC;
		end else if (can_id_s1 == ID_TIME) begin
			res.frame_class = CLS_TIME;
		end else if (base >= BASE_PDO_LO && base <= BASE_TPDO_HI && base[7]) begin
			// tpdo bases 0x180..0x480: number is id bits 10..8
			res.frame_class = CLS_TPDO;
			res.pdo_index   = can_id_s1[10:8];
		end else if (base >= BASE_RPDO_LO && base <= BASE_PDO_HI && !base[7]) begin
			// rpdo bases 0x200..0x500: number is id bits 10..8 minus one
			res.frame_class = CLS_RPDO;
			res.pdo_index   = can_id_s1[10:8] - 3'd1;
		end else if (base == BASE_SDO_TX) begin
			res.frame_class = CLS_SDO_RESP;
			if (data_len_s1 >= 4'd4) begin
				res.sdo_command = b0[7:5];
				if (b0[7:5] == SDO_CS_UPLOAD && b0[1]) begin
					res.word_value  = hi_word & expd_mask;
					res.value_valid = 1'b1;
				end else if (b0[7:5] == SDO_CS_ABORT && data_len_s1 >= 4'd8) begin
					res.word_value   = hi_word;
					res.value_valid  = 1'b1;
					res.abort_reason = abort_lookup(hi_word);
				end
			end
		end else if (base == BASE_SDO_RX) begin
			res.frame_class = CLS_SDO_REQ;
		end else if (base == BASE_HB) begin
			if (data_len_s1 == '0) begin
				res.frame_class = CLS_HB_EMPTY;
			end else if (b0 == '0) begin
				res.frame_class = CLS_BOOTUP;
			end else begin
				res.frame_class = CLS_HEARTBT;
				unique case (b0)
					8'h04:   res.heartbeat_state = HB_STOPPED;
					8'h05:   res.heartbeat_state = HB_OPER;
					8'h7F:   res.heartbeat_state = HB_PREOP;
					default: res.heartbeat_state = HB_UNKNOWN;
				endcase
			end
		end else begin
			res.frame_class = CLS_UNKNOWN;
		end

		// discovery in scan mode
		case (res.frame_class) inside
			CLS_EMCY, CLS_TPDO, CLS_SDO_RESP, CLS_BOOTUP, CLS_HEARTBT, CLS_HB_EMPTY:
				res.node_found = scan_enable_q;
			default:
				res.node_found = 1'b0;
		endcase

		// rejected frames carry nothing
		if (!pass)
			res = '0;
	end

	// result register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (adv_s1) begin
			result_s2 <= res;
		end
	end

	// master side packing
	assign m_axis_tvalid = valid_s2;
	assign m_axis_tuser  = {result_s2.frame_class, result_s2.accepted};
	assign m_axis_tdata  = {6'b000000,
	                        result_s2.abort_reason,
	                        result_s2.value_valid,
	                        result_s2.word_value,
	                        result_s2.sdo_command,
	                        result_s2.heartbeat_state,
	                        result_s2.nmt_target,
	                        result_s2.nmt_command,
	                        result_s2.node_found,
	                        result_s2.pdo_index,
	                        result_s2.node_number};

`ifndef SYNTHESIS
	// rejected frame transfers carry an all-zero result
	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !result_s2.accepted) |-> (result_s2 == '0))
		else $error("rejected frame with nonzero fields");

	// pdo number only on pdo classes
	a_pdo_class: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && result_s2.pdo_index != '0) |->
		(result_s2.frame_class == CLS_TPDO || result_s2.frame_class == CLS_RPDO))
		else $error("pdo index on non-pdo class");

	// decoded value only for emcy or sdo response
	a_value_class: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && result_s2.value_valid) |->
		(result_s2.frame_class == CLS_EMCY || result_s2.frame_class == CLS_SDO_RESP))
		else $error("value on wrong class");

	// abort reason implies a decoded sdo response value
	a_abort_value: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && result_s2.abort_reason != '0) |->
		(result_s2.value_valid && result_s2.frame_class == CLS_SDO_RESP))
		else $error("abort reason without sdo value");

	// node discovery needs scan mode and an accepted frame
	a_found_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && result_s2.node_found) |-> (scan_enable_q && result_s2.accepted))
		else $error("node found outside scan mode");
`endif

endmodule

FILE: tb/sv/tb_canopen_frame_filter_classifier.sv
// self-checking testbench for the canopen frame filter and classifier
`timescale 1ns / 100ps

module tb_canopen_frame_filter_classifier
	import cfc_pkg::*;
();

	// protocol byte values seen in byte 0 of nmt and heartbeat frames
	localparam logic [BYTE_W-1:0] NMT_BYTE_START      = 8'h01;
	localparam logic [BYTE_W-1:0] NMT_BYTE_STOP       = 8'h02;
	localparam logic [BYTE_W-1:0] NMT_BYTE_PREOP      = 8'h80;
	localparam logic [BYTE_W-1:0] NMT_BYTE_RESET_NODE = 8'h81;
	localparam logic [BYTE_W-1:0] NMT_BYTE_RESET_COMM = 8'h82;
	localparam logic [BYTE_W-1:0] HB_BYTE_BOOTUP      = 8'h00;
	localparam logic [BYTE_W-1:0] HB_BYTE_STOPPED     = 8'h04;
	localparam logic [BYTE_W-1:0] HB_BYTE_OPER        = 8'h05;
	localparam logic [BYTE_W-1:0] HB_BYTE_PREOP       = 8'h7F;

	localparam int unsigned STALL_LIMIT   = 2000;
	localparam int unsigned ITEMS_PER_SET = 60;
	localparam int unsigned SETTLE_CYCLES = 4;

	// sdo abort codes in reason order
	localparam logic [WORD_W-1:0] ABORT_CODES [ABORT_N] = '{
		32'h05030000, 32'h05040000, 32'h05040001, 32'h05040002, 32'h05040003,
		32'h05040004, 32'h05040005, 32'h06010000, 32'h06010001, 32'h06010002,
		32'h06020000, 32'h06040041, 32'h06040042, 32'h06040043, 32'h06070010,
		32'h06090011, 32'h06090030, 32'h06090031, 32'h06090032, 32'h08000000,
		32'h08000020, 32'h08000021, 32'h08000022
	};

	// frame classification predictor and store of pending verdicts
	class verdict_board;
		logic                flt_on      = 1'b0;
		logic [CAN_ID_W-1:0] id_lo       = '0;
		logic [CAN_ID_W-1:0] id_hi       = '1;
		logic                node_flt_on = 1'b0;
		logic [NODE_W-1:0]   node_sel    = '0;
		logic [TYPE_W-1:0]   type_sel    = TF_NONE;
		logic                scan_on     = 1'b0;
		cfc_result_t         pending[$];
		int unsigned         fail_count  = 0;

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				REG_FILTER_ENABLE:      flt_on      = data[0];
				REG_ID_MIN:             id_lo       = data[CAN_ID_W-1:0];
				REG_ID_MAX:             id_hi       = data[CAN_ID_W-1:0];
				REG_NODE_FILTER_ENABLE: node_flt_on = data[0];
				REG_NODE_FILTER_ID:     node_sel    = data[NODE_W-1:0];
				REG_TYPE_FILTER:        type_sel    = data[TYPE_W-1:0];
				REG_SCAN_ENABLE:        scan_on     = data[0];
				default: ;
			endcase
		endfunction

		function cfc_result_t classify_frame(logic [CAN_ID_W-1:0] id, logic [LEN_W-1:0] len,
				logic [PAYLOAD_W-1:0] pl);
			cfc_result_t         r;
			logic [CAN_ID_W-1:0] base;
			logic [BYTE_W-1:0]   b0;
			int                  nbytes;
			bit                  pass;
			r    = '0;
			base = id & BASE_MASK;
			b0   = pl[7:0];
			pass = 1'b1;
			// optional filter on range, node and message type
			if (flt_on) begin
				if (id < id_lo || id > id_hi)
					pass = 1'b0;
				if (node_flt_on && id[NODE_W-1:0] != node_sel)
					pass = 1'b0;
				case (type_sel)
					TF_PDO:  if (!(base >= BASE_PDO_LO && base <= BASE_PDO_HI)) pass = 1'b0;
					TF_SDO:  if (!(base == BASE_SDO_TX || base == BASE_SDO_RX)) pass = 1'b0;
					TF_EMCY: if (base != BASE_EMCY) pass = 1'b0;
					TF_NMT:  if (id != '0) pass = 1'b0;
					TF_HB:   if (base != BASE_HB) pass = 1'b0;
					default: ;
				endcase
			end
			if (!pass)
				return r;
			r.accepted    = 1'b1;
			r.node_number = id[NODE_W-1:0];
			// classification by cob-id and payload decode
			if (id == '0) begin
				r.frame_class = CLS_NMT;
				if (len >= 2) begin
					r.nmt_target = pl[15:8];
					case (b0)
						NMT_BYTE_START:      r.nmt_command = NMT_START;
						NMT_BYTE_STOP:       r.nmt_command = NMT_STOP;
						NMT_BYTE_PREOP:      r.nmt_command = NMT_PREOP;
						NMT_BYTE_RESET_NODE: r.nmt_command = NMT_RESET_NODE;
						NMT_BYTE_RESET_COMM: r.nmt_command = NMT_RESET_COMM;
						default:             r.nmt_command = NMT_UNKNOWN;
					endcase
				end else begin
					r.nmt_command = NMT_UNKNOWN;
				end
			end else if (base == BASE_EMCY && id[NODE_W-1:0] != '0) begin
				r.frame_class = CLS_EMCY;
				if (len >= 2) begin
					r.word_value  = {16'h0, pl[15:0]};
					r.value_valid = 1'b1;
				end
			end else if (id == ID_SYNC) begin
				r.frame_class = CLS_SYNC;
			end else if (id == ID_TIME) begin
				r.frame_class = CLS_TIME;
			end else if (base >= BASE_PDO_LO && base <= BASE_TPDO_HI && base[7:0] == 8'h80) begin
				r.frame_class = CLS_TPDO;
				r.pdo_index   = PDO_W'(((base - BASE_PDO_LO) >> 8) + 1);
			end else if (base >= BASE_RPDO_LO && base <= BASE_PDO_HI && base[7:0] == 8'h00) begin
				r.frame_class = CLS_RPDO;
				r.pdo_index   = PDO_W'(((base - BASE_RPDO_LO) >> 8) + 1);
			end else if (base == BASE_SDO_TX) begin
				r.frame_class = CLS_SDO_RESP;
				if (len >= 4) begin
					r.sdo_command = b0[7:5];
					if (b0[7:5] == SDO_CS_UPLOAD && b0[1]) begin
						// expedited upload, b0 bits 3..2 give the unused byte count
						nbytes = 4 - b0[3:2];
						for (int i = 0; i < nbytes; i++)
							r.word_value[8*i +: 8] = pl[32+8*i +: 8];
						r.value_valid = 1'b1;
					end else if (b0[7:5] == SDO_CS_ABORT && len >= 8) begin
						r.word_value  = pl[63:32];
						r.value_valid = 1'b1;
						for (int k = 0; k < ABORT_N; k++)
							if (ABORT_CODES[k] == r.word_value)
								r.abort_reason = REASON_W'(k + 1);
					end
				end
			end else if (base == BASE_SDO_RX) begin
				r.frame_class = CLS_SDO_REQ;
			end else if (base == BASE_HB) begin
				if (len == 0)
					r.frame_class = CLS_HB_EMPTY;
				else if (b0 == HB_BYTE_BOOTUP)
					r.frame_class = CLS_BOOTUP;
				else begin
					r.frame_class = CLS_HEARTBT;
					case (b0)
						HB_BYTE_STOPPED: r.heartbeat_state = HB_STOPPED;
						HB_BYTE_OPER:    r.heartbeat_state = HB_OPER;
						HB_BYTE_PREOP:   r.heartbeat_state = HB_PREOP;
						default:         r.heartbeat_state = HB_UNKNOWN;
					endcase
				end
			end else begin
				r.frame_class = CLS_UNKNOWN;
			end
			// node discovery in scan mode
			if (scan_on && (r.frame_class inside {CLS_EMCY, CLS_TPDO, CLS_SDO_RESP,
					CLS_BOOTUP, CLS_HEARTBT, CLS_HB_EMPTY}))
				r.node_found = 1'b1;
			return r;
		endfunction

		function void note_frame(logic [CAN_ID_W-1:0] id, logic [LEN_W-1:0] len,
				logic [PAYLOAD_W-1:0] pl);
			pending.push_back(classify_frame(id, len, pl));
		endfunction

		function void log_failure(string msg);
			if (fail_count < 10)
				$display("[%0t] mismatch: %s", $realtime, msg);
			fail_count++;
		endfunction

		function void check_result(logic [M_TDATA_W-1:0] tdata, logic [M_TUSER_W-1:0] tuser);
			cfc_result_t e;
			logic [WORD_W-1:0] want[13];
			logic [WORD_W-1:0] got[13];
			string tag[13] = '{"accepted", "frame_class", "node_number", "pdo_index",
				"node_found", "nmt_command", "nmt_target", "heartbeat_state", "sdo_command",
				"word_value", "value_valid", "abort_reason", "tdata pad"};
			if (pending.size() == 0) begin
				log_failure($sformatf("result with nothing pending tdata=%h tuser=%h",
					tdata, tuser));
				return;
			end
			e = pending.pop_front();
			want = '{e.accepted, e.frame_class, e.node_number, e.pdo_index, e.node_found,
				e.nmt_command, e.nmt_target, e.heartbeat_state, e.sdo_command, e.word_value,
				e.value_valid, e.abort_reason, 0};
			got = '{tuser[0], tuser[4:1], tdata[6:0], tdata[9:7], tdata[10], tdata[13:11],
				tdata[21:14], tdata[24:22], tdata[27:25], tdata[59:28], tdata[60],
				tdata[65:61], tdata[71:66]};
			for (int f = 0; f < 13; f++)
				if (want[f] !== got[f])
					log_failure($sformatf("%s expected %h got %h", tag[f], want[f], got[f]));
		endfunction

		function int unsigned total_failures();
			if (pending.size() != 0)
				log_failure($sformatf("%0d results never arrived", pending.size()));
			return fail_count;
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [S_TDATA_W-1:0]  s_axis_tdata = '0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [M_TDATA_W-1:0]  m_axis_tdata;
	logic [M_TUSER_W-1:0]  m_axis_tuser;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	verdict_board board = new();
	int unsigned  send_idle_pct = 0;
	int unsigned  recv_idle_pct = 0;
	int unsigned  stall_cycles = 0;
	logic [NODE_W-1:0] favored_node = '0;

	canopen_frame_filter_classifier i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	// clock
	initial begin
		forever #6 clk = ~clk;
	end

	// result side backpressure
	always @(posedge clk) begin
		m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// handshakes are stable mid-cycle, so results are checked at the falling edge
	always @(negedge clk) begin
		if (m_axis_tvalid && m_axis_tready)
			board.check_result(m_axis_tdata, m_axis_tuser);
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
				(cfg_valid && cfg_ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
	end

	// watchdog on cycles with no transfer at all
	initial begin
		while (stall_cycles < STALL_LIMIT)
			@(posedge clk);
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// one frame transfer, called and returning at a rising edge
	task automatic send_frame(input logic [CAN_ID_W-1:0] id, input logic [LEN_W-1:0] len,
			input logic [PAYLOAD_W-1:0] pl);
		bit fire;
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {1'b0, pl, len, id};
		do begin
			@(negedge clk);
			fire = s_axis_tvalid && s_axis_tready;
			@(posedge clk);
		end while (!fire);
		board.note_frame(id, len, pl);
	endtask

	// write every register, block idle
	task automatic apply_settings(input logic fe, input logic [CAN_ID_W-1:0] lo,
			input logic [CAN_ID_W-1:0] hi, input logic nfe, input logic [NODE_W-1:0] nid,
			input logic [TYPE_W-1:0] tf, input logic scan);
		logic [CFG_IDX_W-1:0]  regs[7];
		logic [CFG_DATA_W-1:0] vals[7];
		bit fire;
		regs = '{REG_FILTER_ENABLE, REG_ID_MIN, REG_ID_MAX, REG_NODE_FILTER_ENABLE,
			REG_NODE_FILTER_ID, REG_TYPE_FILTER, REG_SCAN_ENABLE};
		vals = '{fe, lo, hi, nfe, nid, tf, scan};
		favored_node = nid;
		for (int i = 0; i < 7; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= regs[i];
			cfg_data  <= vals[i];
			do begin
				@(negedge clk);
				fire = cfg_valid && cfg_ready;
				@(posedge clk);
			end while (!fire);
			board.set_reg(regs[i], vals[i]);
		end
		cfg_valid <= 1'b0;
	endtask

	// stop sending and wait until every verdict is back
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (board.pending.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// random frame, mostly well formed for one of the cob-id classes
	task automatic send_random_frame();
		logic [CAN_ID_W-1:0]  id;
		logic [LEN_W-1:0]     len;
		logic [PAYLOAD_W-1:0] pl;
		logic [NODE_W-1:0]    node;
		logic [BYTE_W-1:0]    pick[6];
		logic [2:0]           cs;
		node = $urandom_range(1) ? favored_node : NODE_W'($urandom_range(127));
		pl   = {$urandom, $urandom};
		len  = ($urandom_range(9) == 0) ? LEN_W'($urandom_range(15, 9))
			: LEN_W'($urandom_range(8));
		case ($urandom_range(11))
			0: begin
				id   = '0;
				pick = '{NMT_BYTE_START, NMT_BYTE_STOP, NMT_BYTE_PREOP, NMT_BYTE_RESET_NODE,
					NMT_BYTE_RESET_COMM, pl[7:0]};
				pl[7:0] = pick[$urandom_range(5)];
			end
			1: id = ID_SYNC;
			2: id = ID_TIME;
			3: id = BASE_EMCY | node;
			4, 5: id = CAN_ID_W'(BASE_PDO_LO + 11'h80 * $urandom_range(7)) | node;
			6, 7: begin
				id = BASE_SDO_TX | node;
				case ($urandom_range(4))
					0, 1: cs = SDO_CS_UPLOAD;
					2, 3: cs = SDO_CS_ABORT;
					default: cs = pl[7:5];
				endcase
				pl[7:5] = cs;
				if (cs == SDO_CS_ABORT && $urandom_range(1))
					pl[63:32] = ABORT_CODES[$urandom_range(ABORT_N - 1)];
				if ($urandom_range(1))
					len = 4'd8;
			end
			8: id = BASE_SDO_RX | node;
			9, 10: begin
				id   = BASE_HB | node;
				pick = '{HB_BYTE_BOOTUP, HB_BYTE_STOPPED, HB_BYTE_OPER, HB_BYTE_PREOP,
					pl[7:0], pl[7:0]};
				pl[7:0] = pick[$urandom_range(5)];
			end
			default: id = CAN_ID_W'($urandom_range(2047));
		endcase
		send_frame(id, len, pl);
	endtask

	// idle pattern per phase
	task automatic set_idling(input int mode);
		case (mode)
			0: begin send_idle_pct = 34; recv_idle_pct = 47; end
			1: begin send_idle_pct = 47; recv_idle_pct = 34; end
			default: begin send_idle_pct = 0; recv_idle_pct = 0; end
		endcase
	endtask

	// main sequence
	initial begin
		logic [CAN_ID_W-1:0] lo;
		logic [CAN_ID_W-1:0] hi;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// filter off with an inverted id range and the node and type filters set, scan on
		set_idling(0);
		apply_settings(1'b0, 11'h7FF, 11'h000, 1'b1, 7'd5, TF_HB, 1'b1);

		// nmt commands, unknown command byte and short frame
		send_frame(11'h000, 4'd2, {48'h0, 8'h2A, NMT_BYTE_START});
		send_frame(11'h000, 4'd8, {48'hFFFF_FFFF_FFFF, 8'hFF, NMT_BYTE_STOP});
		send_frame(11'h000, 4'd2, {48'h0, 8'h00, NMT_BYTE_PREOP});
		send_frame(11'h000, 4'd3, {48'h0, 8'h7F, NMT_BYTE_RESET_NODE});
		send_frame(11'h000, 4'd2, {48'h0, 8'h01, NMT_BYTE_RESET_COMM});
		send_frame(11'h000, 4'd2, {48'h0, 8'h11, 8'h33});
		send_frame(11'h000, 4'd1, {48'h0, 8'h11, NMT_BYTE_START});
		// sync on the emcy base, emcy full and short, time
		send_frame(ID_SYNC, 4'd0, 64'h0);
		send_frame(11'h081, 4'd2, 64'h0000_0000_0000_1000);
		send_frame(11'h0FF, 4'd1, 64'hFFFF_FFFF_FFFF_FFFF);
		send_frame(ID_TIME, 4'd6, 64'h0123_4567_89AB_CDEF);
		// pdo extremes
		send_frame(11'h1FF, 4'd8, 64'hFFFF_FFFF_FFFF_FFFF);
		send_frame(11'h481, 4'd4, 64'h0);
		send_frame(11'h57F, 4'd0, 64'h0);
		// sdo response: expedited full and one byte, segmented, aborts, short
		send_frame(11'h5FF, 4'd8, {32'hDEAD_BEEF, 24'h0, SDO_CS_UPLOAD, 5'b00011});
		send_frame(11'h581, 4'd8, {32'hDEAD_BEEF, 24'h0, SDO_CS_UPLOAD, 5'b01111});
		send_frame(11'h581, 4'd8, {32'hDEAD_BEEF, 24'h0, SDO_CS_UPLOAD, 5'b00001});
		send_frame(11'h582, 4'd8, {ABORT_CODES[ABORT_N-1], 24'h0, SDO_CS_ABORT, 5'b0});
		send_frame(11'h582, 4'd15, {32'hFFFF_FFFF, 24'h0, SDO_CS_ABORT, 5'b0});
		send_frame(11'h582, 4'd7, {ABORT_CODES[0], 24'h0, SDO_CS_ABORT, 5'b0});
		send_frame(11'h583, 4'd3, {32'hDEAD_BEEF, 24'h0, SDO_CS_UPLOAD, 5'b00011});
		send_frame(11'h601, 4'd8, 64'h1122_3344_5566_7788);
		// heartbeat: empty, bootup, each state, unknown state
		send_frame(11'h77F, 4'd0, 64'hFFFF_FFFF_FFFF_FF05);
		send_frame(11'h701, 4'd1, {56'h0, HB_BYTE_BOOTUP});
		send_frame(11'h705, 4'd1, {56'h0, HB_BYTE_STOPPED});
		send_frame(11'h706, 4'd1, {56'h0, HB_BYTE_OPER});
		send_frame(11'h707, 4'd1, {56'h0, HB_BYTE_PREOP});
		send_frame(11'h708, 4'd15, {56'h0, 8'hAA});
		// unused function code
		send_frame(11'h7FF, 4'd15, 64'hFFFF_FFFF_FFFF_FFFF);
		drain();

		// random phases, one filter setting each
		for (int phase = 0; phase < 8; phase++) begin
			set_idling(phase < 2 ? 0 : (phase < 5 ? 1 : 2));
			lo = CAN_ID_W'($urandom_range(1024));
			hi = CAN_ID_W'($urandom_range(2047, lo));
			case (phase)
				0: apply_settings(1'b1, 11'h000, 11'h7FF, 1'b0, 7'd0, TF_NONE, 1'b1);
				1: apply_settings(1'b1, 11'h180, 11'h57F, 1'b1, 7'd127, TF_PDO, 1'b1);
				2: apply_settings(1'b1, lo, hi, 1'b0, NODE_W'($urandom_range(127)),
					TF_SDO, 1'b0);
				3: apply_settings(1'b1, 11'h000, 11'h7FF, 1'b1, 7'd0, TF_EMCY, 1'b1);
				4: apply_settings(1'b1, 11'h000, 11'h000, 1'b0, 7'd0, TF_NMT, 1'b1);
				5: apply_settings(1'b1, 11'h700, 11'h7FF, 1'($urandom_range(1)),
					NODE_W'($urandom_range(127)), TF_HB, 1'b1);
				6: apply_settings(1'b1, 11'h100, 11'h6FF, 1'b0, 7'd0, 3'd6, 1'b1);
				default: apply_settings(1'b1, 11'h000, 11'h7FF, 1'b1,
					NODE_W'($urandom_range(127)), 3'd7, 1'b1);
			endcase
			repeat (ITEMS_PER_SET) send_random_frame();
			drain();
		end

		if (board.total_failures() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

FILE: files.f
hw/rtl/cfc_pkg.sv
hw/rtl/canopen_frame_filter_classifier.sv
tb/sv/tb_canopen_frame_filter_classifier.sv
